// ----- src/iwwc_pkg.sv -----
// Shared types and constants of the intensity-weighted window centroid.
// Payload structs, controller command/status structs and register indexes.
// No dependencies.
package iwwc_pkg;

    localparam int PIX_W = 8;
    localparam int REG_W = 13;
    localparam int OUT_W = 12;
    localparam int SUM_W = 32;
    localparam int MOM_W = 44;
    // Divider numerator 2*m + s and denominator 2*s
    localparam int NUM_W = MOM_W + 2;
    localparam int DEN_W = SUM_W + 1;
    localparam int Q_STEPS = OUT_W;
    localparam int STEP_W = $clog2(Q_STEPS);
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEFT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_TOP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_RIGHT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_BOTTOM  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 3'd4;

    localparam logic [REG_W-1:0] IMAGE_WIDTH_RESET = 13'd4096;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             frame_end;
    } pix_in_t;

    typedef struct packed {
        logic [OUT_W-1:0] center_x;
        logic [OUT_W-1:0] center_y;
        logic             empty_res;
    } cent_out_t;

    typedef struct packed {
        logic accept;    // pixel taken this cycle
        logic div_load;  // frame end taken: snapshot sums into dividers
        logic div_step;  // one quotient bit
        logic out_load;  // move result into output register
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;  // output register empty or being drained
    } dp_stat_t;

endpackage

// ----- src/iwwc_div.sv -----
// Restoring divider, one quotient bit per step, saturating at the output width.
// Computes floor(num / den) clipped to all ones. Uses iwwc_pkg.
module iwwc_div (
    input  logic                           aclk,
    input  logic                           load,
    input  logic                           step,
    input  logic [iwwc_pkg::NUM_W-1:0]     num,
    input  logic [iwwc_pkg::DEN_W-1:0]     den,
    output logic [iwwc_pkg::OUT_W-1:0]     quot
);

    logic [iwwc_pkg::NUM_W-1:0] rem_reg, rem_next;
    logic [iwwc_pkg::NUM_W-1:0] dsh_reg, dsh_next;
    logic [iwwc_pkg::OUT_W-1:0] q_reg, q_next;
    logic                       ovf_reg, ovf_next;
    logic                       fits;

    assign fits = rem_reg >= dsh_reg;

    always_comb begin
        rem_next = rem_reg;
        dsh_next = dsh_reg;
        q_next   = q_reg;
        ovf_next = ovf_reg;
        if (load) begin
            rem_next = num;
            dsh_next = iwwc_pkg::NUM_W'(den) << (iwwc_pkg::Q_STEPS - 1);
            q_next   = '0;
            // quotient too large for the output: clip
            ovf_next = num >= (iwwc_pkg::NUM_W'(den) << iwwc_pkg::Q_STEPS);
        end else if (step) begin
            if (fits) begin
                rem_next = rem_reg - dsh_reg;
            end
            q_next   = {q_reg[iwwc_pkg::OUT_W-2:0], fits};
            dsh_next = dsh_reg >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
        ovf_reg <= ovf_next;
    end

    assign quot = ovf_reg ? '1 : q_reg;

endmodule

// ----- src/iwwc_ctrl.sv -----
// Controller of the centroid block: accumulate, divide, hand over result.
// Drives the datapath through iwwc_pkg::ctrl_cmd_t. Uses iwwc_pkg.
module iwwc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  frame_end,
    output logic                  s_ready,
    input  iwwc_pkg::dp_stat_t    stat,
    output iwwc_pkg::ctrl_cmd_t   cmd
);

    localparam logic [1:0] ST_ACC  = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [iwwc_pkg::STEP_W-1:0] LAST_STEP =
        iwwc_pkg::STEP_W'(iwwc_pkg::Q_STEPS - 1);

    logic [1:0]                  state_reg, state_next;
    logic [iwwc_pkg::STEP_W-1:0] step_reg, step_next;

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        s_ready      = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_ACC: begin
                s_ready      = 1'b1;
                cmd.accept   = s_valid;
                cmd.div_load = s_valid && frame_end;
                if (s_valid && frame_end) begin
                    state_next = ST_DIV;
                    step_next  = '0;
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == LAST_STEP) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register can take the result
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_ACC;
                end
            end
            default: begin
                state_next = ST_ACC;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_ACC;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    a_last_step_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && step_reg == LAST_STEP) |=> (state_reg == ST_DONE))
        else $error("divider did not finish after the last step");

    a_no_accept_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_step |-> (!s_ready && !cmd.accept))
        else $error("pixel taken while dividing");

    a_load_returns: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> (state_reg == ST_ACC && s_ready))
        else $error("no return to accumulation after result");

endmodule

// ----- src/iwwc_dp.sv -----
// Datapath of the centroid block: configuration registers, raster counters,
// window moments, two dividers and the output register. Uses iwwc_pkg, iwwc_div.
module iwwc_dp #(
    parameter int MAX_DIM = 4096
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [iwwc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [iwwc_pkg::REG_W-1:0]      cfg_data,
    input  iwwc_pkg::pix_in_t               s_data,
    output iwwc_pkg::cent_out_t             m_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    input  iwwc_pkg::ctrl_cmd_t             cmd,
    output iwwc_pkg::dp_stat_t              stat
);

    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int CMP_W = (CNT_W + 1 > iwwc_pkg::REG_W) ? CNT_W + 1 : iwwc_pkg::REG_W;
    localparam int PRD_W = CNT_W + iwwc_pkg::PIX_W;
    localparam logic [CMP_W-1:0] DIM_C   = CMP_W'(MAX_DIM);
    localparam logic [CNT_W-1:0] ROW_TOP = CNT_W'(MAX_DIM - 1);

    logic [iwwc_pkg::REG_W-1:0] win_left_reg, win_top_reg, win_right_reg, win_bottom_reg;
    logic [iwwc_pkg::REG_W-1:0] img_width_reg;

    logic [CNT_W-1:0]           col_reg, col_next, row_reg, row_next;
    logic [iwwc_pkg::SUM_W-1:0] sum_reg, sum_next, sum_add;
    logic [iwwc_pkg::MOM_W-1:0] xm_reg, xm_next, xm_add;
    logic [iwwc_pkg::MOM_W-1:0] ym_reg, ym_next, ym_add;

    logic [CMP_W-1:0] width_ext, width_eff, col_ext, row_ext;
    logic             in_win, col_last;
    logic [PRD_W-1:0] x_prod, y_prod;

    logic [iwwc_pkg::NUM_W-1:0] x_num, y_num;
    logic [iwwc_pkg::DEN_W-1:0] den;
    logic [iwwc_pkg::OUT_W-1:0] qx, qy;
    logic                       empty_reg;

    logic [iwwc_pkg::REG_W:0]   cx_sum, cy_sum;
    logic [iwwc_pkg::OUT_W-1:0] cx_sat, cy_sat;

    logic                 m_valid_reg, m_valid_next;
    iwwc_pkg::cent_out_t  m_data_reg;

    // Configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            win_left_reg   <= '0;
            win_top_reg    <= '0;
            win_right_reg  <= '0;
            win_bottom_reg <= '0;
            img_width_reg  <= iwwc_pkg::IMAGE_WIDTH_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                iwwc_pkg::CFG_WIN_LEFT:    win_left_reg   <= cfg_data;
                iwwc_pkg::CFG_WIN_TOP:     win_top_reg    <= cfg_data;
                iwwc_pkg::CFG_WIN_RIGHT:   win_right_reg  <= cfg_data;
                iwwc_pkg::CFG_WIN_BOTTOM:  win_bottom_reg <= cfg_data;
                iwwc_pkg::CFG_IMAGE_WIDTH: img_width_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Raster position and window test
    always_comb begin
        width_ext = CMP_W'(img_width_reg);
        width_eff = (img_width_reg == '0 || width_ext > DIM_C) ? DIM_C : width_ext;
        col_ext   = CMP_W'(col_reg);
        row_ext   = CMP_W'(row_reg);
        in_win    = col_ext >= CMP_W'(win_left_reg) && col_ext < CMP_W'(win_right_reg) &&
                    row_ext >= CMP_W'(win_top_reg)  && row_ext < CMP_W'(win_bottom_reg);
        col_last  = CMP_W'(col_ext + CMP_W'(1)) >= width_eff;
        x_prod    = PRD_W'(col_reg) * PRD_W'(s_data.pixel);
        y_prod    = PRD_W'(row_reg) * PRD_W'(s_data.pixel);
        sum_add   = in_win ? sum_reg + iwwc_pkg::SUM_W'(s_data.pixel) : sum_reg;
        xm_add    = in_win ? xm_reg + iwwc_pkg::MOM_W'(x_prod) : xm_reg;
        ym_add    = in_win ? ym_reg + iwwc_pkg::MOM_W'(y_prod) : ym_reg;
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        sum_next = sum_reg;
        xm_next  = xm_reg;
        ym_next  = ym_reg;
        if (cmd.accept) begin
            if (s_data.frame_end) begin
                // frame done: sums go to the dividers, start the next frame clean
                col_next = '0;
                row_next = '0;
                sum_next = '0;
                xm_next  = '0;
                ym_next  = '0;
            end else begin
                sum_next = sum_add;
                xm_next  = xm_add;
                ym_next  = ym_add;
                if (col_last) begin
                    col_next = '0;
                    row_next = (row_reg == ROW_TOP) ? '0 : row_reg + 1'b1;
                end else begin
                    col_next = col_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            sum_reg <= '0;
            xm_reg  <= '0;
            ym_reg  <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
            sum_reg <= sum_next;
            xm_reg  <= xm_next;
            ym_reg  <= ym_next;
        end
    end

    // Rounded half up: floor((2m + s) / 2s)
    assign x_num = iwwc_pkg::NUM_W'({xm_add, 1'b0}) + iwwc_pkg::NUM_W'(sum_add);
    assign y_num = iwwc_pkg::NUM_W'({ym_add, 1'b0}) + iwwc_pkg::NUM_W'(sum_add);
    assign den   = {sum_add, 1'b0};

    always_ff @(posedge aclk) begin
        if (cmd.div_load) begin
            empty_reg <= (sum_add == '0);
        end
    end

    iwwc_div u_div_x (
        .aclk (aclk),
        .load (cmd.div_load),
        .step (cmd.div_step),
        .num  (x_num),
        .den  (den),
        .quot (qx)
    );

    iwwc_div u_div_y (
        .aclk (aclk),
        .load (cmd.div_load),
        .step (cmd.div_step),
        .num  (y_num),
        .den  (den),
        .quot (qy)
    );

    // Window centre for an empty frame, truncated and clipped
    always_comb begin
        cx_sum = {1'b0, win_left_reg} + {1'b0, win_right_reg};
        cy_sum = {1'b0, win_top_reg}  + {1'b0, win_bottom_reg};
        cx_sat = cx_sum[iwwc_pkg::REG_W] ? '1 : cx_sum[iwwc_pkg::OUT_W:1];
        cy_sat = cy_sum[iwwc_pkg::REG_W] ? '1 : cy_sum[iwwc_pkg::OUT_W:1];
    end

    // Output register
    assign stat.out_free = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg.center_x  <= empty_reg ? cx_sat : qx;
            m_data_reg.center_y  <= empty_reg ? cy_sat : qy;
            m_data_reg.empty_res <= empty_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten before it was taken");

    a_frame_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept && s_data.frame_end) |=>
            (sum_reg == '0 && xm_reg == '0 && ym_reg == '0 && col_reg == '0 && row_reg == '0))
        else $error("frame state not cleared after frame end");

endmodule

// ----- src/intensity_weighted_window_centroid_top.sv -----
// Top level of the intensity-weighted window centroid.
// Joins iwwc_ctrl and iwwc_dp. Uses iwwc_pkg.
//
// Usage:
//   s_ channel: one 8-bit pixel per item in raster order; frame_end marks the
//   last pixel of a frame. m_ channel: one centroid item per frame.
//   cfg_ channel: register index and 13-bit data (0 win_left, 1 win_top,
//   2 win_right, 3 win_bottom, 4 image_width); always ready, write only
//   while no frame is in flight.
// Throughput: one pixel per cycle inside a frame. After a frame_end item
//   s_ready stays low while the two bit-serial dividers work (one
//   quotient bit each per cycle) and while the result is loaded. It stays
//   low longer while the previous result still waits in the output register.
// The result enters the output register when the dividers have finished.
// The output register holds the result until m_ready; pixels of the next
//   frame are taken meanwhile.
// Reset (aresetn low, synchronous): window bounds 0, image_width 4096,
//   counters and sums cleared, no result pending.
module intensity_weighted_window_centroid_top #(
    parameter int MAX_DIM = 4096
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  iwwc_pkg::pix_in_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output iwwc_pkg::cent_out_t             m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [iwwc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [iwwc_pkg::REG_W-1:0]      cfg_data
);

    iwwc_pkg::ctrl_cmd_t cmd;
    iwwc_pkg::dp_stat_t  stat;

    assign cfg_ready = 1'b1;

    iwwc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .frame_end (s_data.frame_end),
        .s_ready   (s_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    iwwc_dp #(
        .MAX_DIM (MAX_DIM)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_data    (s_data),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule
